@@ hdl/uvs_pkg.sv @@
// Shared types, constants and helper functions of the UV sphere mesh generator.
package uvs_pkg;

    localparam int MAX_SECTORS      = 255;
    localparam int TRIG_BITS_DEF    = 10;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int CORDIC_STEPS     = 20;
    localparam int CORDIC_W         = 34;
    localparam int DIV_Q            = 17;
    localparam int DIV_W            = 25;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;

    localparam logic [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS = 2'd1;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_CELL   = 1'b1;

    localparam logic [15:0] RADIUS_RESET  = 16'd256;
    localparam logic [7:0]  SECTORS_RESET = 8'd16;

    typedef struct packed {
        logic        is_cell;
        logic [15:0] k1;
        logic [15:0] k2;
        logic        has_first;
        logic        has_second;
    } t_side;

    typedef struct packed {
        t_side      side;
        logic [7:0] n;
        logic [7:0] i;
        logic [7:0] j;
    } t_q_item;

    typedef struct packed {
        logic        last;
        logic [16:0] pos_x;
        logic [16:0] pos_y;
        logic [16:0] pos_z;
        logic [15:0] norm_x;
        logic [15:0] norm_y;
        logic [15:0] norm_z;
        logic [16:0] tex_s;
        logic [16:0] tex_t;
        logic [15:0] tri_first;
        logic [15:0] tri_second;
        logic [15:0] tri_third;
    } t_res;

    // atan(2^-k) in units of 2^-32 turn
    function automatic logic [CORDIC_W-1:0] atan_turn(input int k);
        logic [CORDIC_W-1:0] v;
        case (k)
            0:       v = CORDIC_W'(536870912);
            1:       v = CORDIC_W'(316933406);
            2:       v = CORDIC_W'(167458907);
            3:       v = CORDIC_W'(85004756);
            4:       v = CORDIC_W'(42667331);
            5:       v = CORDIC_W'(21354465);
            6:       v = CORDIC_W'(10679838);
            7:       v = CORDIC_W'(5340245);
            8:       v = CORDIC_W'(2670163);
            9:       v = CORDIC_W'(1335087);
            10:      v = CORDIC_W'(667544);
            11:      v = CORDIC_W'(333772);
            12:      v = CORDIC_W'(166886);
            13:      v = CORDIC_W'(83443);
            14:      v = CORDIC_W'(41722);
            15:      v = CORDIC_W'(20861);
            16:      v = CORDIC_W'(10430);
            17:      v = CORDIC_W'(5215);
            18:      v = CORDIC_W'(2608);
            19:      v = CORDIC_W'(1304);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/uvs_ifs.sv @@
// Valid/ready channel interfaces for input items and result beats.
interface uvs_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] stack_index;
    logic [7:0] sector_index;

    modport source(output valid, opcode, stack_index, sector_index, input ready);
    modport sink(input valid, opcode, stack_index, sector_index, output ready);
endinterface

interface uvs_res_if;
    logic        valid;
    logic        ready;
    logic        last;
    logic [16:0] pos_x;
    logic [16:0] pos_y;
    logic [16:0] pos_z;
    logic [15:0] norm_x;
    logic [15:0] norm_y;
    logic [15:0] norm_z;
    logic [16:0] tex_s;
    logic [16:0] tex_t;
    logic [15:0] tri_first;
    logic [15:0] tri_second;
    logic [15:0] tri_third;

    modport source(output valid, last, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                   tex_s, tex_t, tri_first, tri_second, tri_third, input ready);
    modport sink(input valid, last, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                 tex_s, tex_t, tri_first, tri_second, tri_third, output ready);
endinterface

@@ hdl/uvs_front.sv @@
// Front end: accepts items, clamps count and indices, works out cell vertex indices.
module uvs_front import uvs_pkg::*; (
    uvs_item_if.sink i_item,
    input  logic [7:0] i_sectors,
    input  logic       i_full,
    output logic       o_push,
    output t_q_item    o_entry
);

    logic [7:0]  n;
    logic [7:0]  lim;
    logic [7:0]  ic;
    logic [7:0]  jc;
    logic [16:0] k1w;
    logic [16:0] k2w;
    logic        is_cell;

    assign is_cell = (i_item.opcode == OP_CELL);

    always_comb begin
        if (i_sectors < 8'd2) begin
            n = 8'd2;
        end else if (int'(i_sectors) > MAX_SECTORS) begin
            n = 8'(MAX_SECTORS);
        end else begin
            n = i_sectors;
        end
    end

    assign lim = is_cell ? n - 8'd1 : n;
    assign ic  = (i_item.stack_index  > lim) ? lim : i_item.stack_index;
    assign jc  = (i_item.sector_index > lim) ? lim : i_item.sector_index;

    assign k1w = 17'(ic) * 17'({1'b0, n} + 9'd1) + 17'(jc);
    assign k2w = k1w + 17'(n) + 17'd1;

    assign i_item.ready = !i_full;
    assign o_push       = i_item.valid && !i_full;

    always_comb begin
        o_entry                 = '0;
        o_entry.n               = n;
        o_entry.i               = ic;
        o_entry.j               = jc;
        o_entry.side.is_cell    = is_cell;
        o_entry.side.k1         = k1w[15:0];
        o_entry.side.k2         = k2w[15:0];
        o_entry.side.has_first  = (ic != 8'd0);
        o_entry.side.has_second = (ic != n - 8'd1);
    end

endmodule

@@ hdl/uvs_queue.sv @@
// Short queue of classified items between front and back end.
module uvs_queue import uvs_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_entry,
    input  logic    i_pop,
    output t_q_item o_head,
    output logic    o_full,
    output logic    o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_q_item         r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> (r_count < CW'(DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");

endmodule

@@ hdl/uvs_back.sv @@
// Back end: divider, CORDIC and multiply pipeline, output register with triangle split.
module uvs_back import uvs_pkg::*; #(
    parameter int TRIG_TABLE_BITS = TRIG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_radius,
    input  logic        i_empty,
    input  t_q_item     i_head,
    output logic        o_pop,
    output logic        o_valid,
    output t_res        o_res,
    input  logic        i_ready
);

    localparam int B   = TRIG_TABLE_BITS;
    localparam int XW  = CORDIC_W;
    localparam int LAT = (DIV_Q + 1) + (CORDIC_STEPS + 1) + 4;

    typedef struct packed {
        logic [3:0][DIV_W-1:0] rem;
        logic [3:0][DIV_Q-1:0] quo;
        logic [7:0]            n;
        t_side                 side;
    } t_dv;

    typedef struct packed {
        logic [1:0][XW-1:0] x;
        logic [1:0][XW-1:0] y;
        logic [1:0][XW-1:0] z;
        logic [1:0][1:0]    quad;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        t_side              side;
    } t_cd;

    typedef struct packed {
        logic signed [15:0] cs;
        logic signed [15:0] ss;
        logic signed [15:0] ct;
        logic signed [15:0] st;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        t_side              side;
    } t_tg;

    typedef struct packed {
        logic signed [32:0] xy;
        logic signed [31:0] nxp;
        logic signed [31:0] nyp;
        logic signed [32:0] pzp;
        logic signed [15:0] cs;
        logic signed [15:0] ss;
        logic signed [15:0] st;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        t_side              side;
    } t_m1;

    typedef struct packed {
        logic signed [48:0] pxp;
        logic signed [48:0] pyp;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [16:0] pz;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        t_side              side;
    } t_m2;

    typedef struct packed {
        logic signed [16:0] px;
        logic signed [16:0] py;
        logic signed [16:0] pz;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        t_side              side;
    } t_m3;

    function automatic logic signed [15:0] to_q14(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        logic signed [15:0]   r;
        t = (v + 34'sd32768) >>> 16;
        if (t > 34'sd16384) begin
            r = 16'sd16384;
        end else if (t < -34'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
        logic signed [15:0] r;
        if (v > 49'sd16384) begin
            r = 16'sd16384;
        end else if (v < -49'sd16384) begin
            r = -16'sd16384;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [48:0] v);
        logic signed [16:0] r;
        if (v > 49'sd65535) begin
            r = 17'sd65535;
        end else if (v < -49'sd65535) begin
            r = -17'sd65535;
        end else begin
            r = v[16:0];
        end
        return r;
    endfunction

    t_dv  r_dv [DIV_Q + 1];
    t_cd  r_cd [CORDIC_STEPS + 1];
    t_tg  r_tg;
    t_m1  r_m1;
    t_m2  r_m2;
    t_m3  r_m3;

    logic [LAT-1:0] r_vld;
    logic           r_out_valid;
    t_res           r_out;
    logic           r_pend;
    t_res           r_sec;

    logic adv;
    logic out_free;

    assign out_free = !r_out_valid || i_ready;
    assign adv      = out_free && !r_pend;
    assign o_pop    = adv && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], o_pop};
        end
    end

    // dividends: sector phase, stack phase, tex s, tex t (all round half up)
    t_dv n_dv0;
    always_comb begin
        n_dv0        = '0;
        n_dv0.n      = i_head.n;
        n_dv0.side   = i_head.side;
        n_dv0.rem[0] = (DIV_W'(i_head.j) << B) + DIV_W'(i_head.n >> 1);
        n_dv0.rem[1] = (DIV_W'(i_head.i) << (B - 1)) + DIV_W'(i_head.n >> 1);
        n_dv0.rem[2] = (DIV_W'(i_head.j) << 16) + DIV_W'(i_head.n >> 1);
        n_dv0.rem[3] = (DIV_W'(i_head.i) << 16) + DIV_W'(i_head.n >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv[0] <= n_dv0;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar s = 0; s < DIV_Q; s++) begin : g_div
        localparam int K = DIV_Q - 1 - s;
        t_dv              n_dv;
        logic [DIV_W-1:0] dsh;
        assign dsh = DIV_W'(r_dv[s].n) << K;
        always_comb begin
            n_dv = r_dv[s];
            for (int l = 0; l < 4; l++) begin
                if (r_dv[s].rem[l] >= dsh) begin
                    n_dv.rem[l]    = r_dv[s].rem[l] - dsh;
                    n_dv.quo[l][K] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv[s + 1] <= n_dv;
            end
        end
    end

    // phases and CORDIC seed; lane 0 sector, lane 1 stack
    logic [B-1:0] ph_sec;
    logic [B-1:0] ph_stk;
    t_cd          n_cd0;

    assign ph_sec = r_dv[DIV_Q].quo[0][B-1:0];
    assign ph_stk = B'(1 << (B - 2)) - r_dv[DIV_Q].quo[1][B-1:0];

    always_comb begin
        n_cd0         = '0;
        n_cd0.x[0]    = CORDIC_GAIN;
        n_cd0.x[1]    = CORDIC_GAIN;
        n_cd0.z[0]    = XW'({ph_sec[B-3:0], {(32 - B){1'b0}}});
        n_cd0.z[1]    = XW'({ph_stk[B-3:0], {(32 - B){1'b0}}});
        n_cd0.quad[0] = ph_sec[B-1:B-2];
        n_cd0.quad[1] = ph_stk[B-1:B-2];
        n_cd0.tex_s   = r_dv[DIV_Q].quo[2];
        n_cd0.tex_t   = r_dv[DIV_Q].quo[3];
        n_cd0.side    = r_dv[DIV_Q].side;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cd[0] <= n_cd0;
        end
    end

    for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cordic
        t_cd n_cd;
        always_comb begin
            n_cd = r_cd[s];
            for (int l = 0; l < 2; l++) begin
                if (!r_cd[s].z[l][XW-1]) begin
                    n_cd.x[l] = $signed(r_cd[s].x[l]) - ($signed(r_cd[s].y[l]) >>> s);
                    n_cd.y[l] = $signed(r_cd[s].y[l]) + ($signed(r_cd[s].x[l]) >>> s);
                    n_cd.z[l] = r_cd[s].z[l] - atan_turn(s);
                end else begin
                    n_cd.x[l] = $signed(r_cd[s].x[l]) + ($signed(r_cd[s].y[l]) >>> s);
                    n_cd.y[l] = $signed(r_cd[s].y[l]) - ($signed(r_cd[s].x[l]) >>> s);
                    n_cd.z[l] = r_cd[s].z[l] + atan_turn(s);
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cd[s + 1] <= n_cd;
            end
        end
    end

    // round to Q1.14 and fold quadrant back in
    t_tg                n_tg;
    logic signed [15:0] cr [2];
    logic signed [15:0] sr [2];
    logic signed [15:0] co [2];
    logic signed [15:0] so [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            cr[l] = to_q14($signed(r_cd[CORDIC_STEPS].x[l]));
            sr[l] = to_q14($signed(r_cd[CORDIC_STEPS].y[l]));
            case (r_cd[CORDIC_STEPS].quad[l])
                2'd0: begin
                    co[l] = cr[l];
                    so[l] = sr[l];
                end
                2'd1: begin
                    co[l] = -sr[l];
                    so[l] = cr[l];
                end
                2'd2: begin
                    co[l] = -cr[l];
                    so[l] = -sr[l];
                end
                default: begin
                    co[l] = sr[l];
                    so[l] = -cr[l];
                end
            endcase
        end
        n_tg.cs    = co[0];
        n_tg.ss    = so[0];
        n_tg.ct    = co[1];
        n_tg.st    = so[1];
        n_tg.tex_s = r_cd[CORDIC_STEPS].tex_s;
        n_tg.tex_t = r_cd[CORDIC_STEPS].tex_t;
        n_tg.side  = r_cd[CORDIC_STEPS].side;
    end

    // products
    t_m1                n_m1;
    logic signed [16:0] rr;
    assign rr = $signed({1'b0, i_radius});

    always_comb begin
        n_m1.xy    = rr * r_tg.ct;
        n_m1.nxp   = r_tg.ct * r_tg.cs;
        n_m1.nyp   = r_tg.ct * r_tg.ss;
        n_m1.pzp   = rr * r_tg.st;
        n_m1.cs    = r_tg.cs;
        n_m1.ss    = r_tg.ss;
        n_m1.st    = r_tg.st;
        n_m1.tex_s = r_tg.tex_s;
        n_m1.tex_t = r_tg.tex_t;
        n_m1.side  = r_tg.side;
    end

    t_m2 n_m2;
    always_comb begin
        n_m2.pxp   = r_m1.xy * r_m1.cs;
        n_m2.pyp   = r_m1.xy * r_m1.ss;
        n_m2.nx    = sat16((49'(r_m1.nxp) + 49'sd8192) >>> 14);
        n_m2.ny    = sat16((49'(r_m1.nyp) + 49'sd8192) >>> 14);
        n_m2.nz    = r_m1.st;
        n_m2.pz    = sat17((49'(r_m1.pzp) + 49'sd8192) >>> 14);
        n_m2.tex_s = r_m1.tex_s;
        n_m2.tex_t = r_m1.tex_t;
        n_m2.side  = r_m1.side;
    end

    t_m3 n_m3;
    always_comb begin
        n_m3.px    = sat17((r_m2.pxp + 49'sd134217728) >>> 28);
        n_m3.py    = sat17((r_m2.pyp + 49'sd134217728) >>> 28);
        n_m3.pz    = r_m2.pz;
        n_m3.nx    = r_m2.nx;
        n_m3.ny    = r_m2.ny;
        n_m3.nz    = r_m2.nz;
        n_m3.tex_s = r_m2.tex_s;
        n_m3.tex_t = r_m2.tex_t;
        n_m3.side  = r_m2.side;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tg <= n_tg;
            r_m1 <= n_m1;
            r_m2 <= n_m2;
            r_m3 <= n_m3;
        end
    end

    // result beats
    t_res vres;
    t_res tri_a;
    t_res tri_b;
    t_res first_res;

    always_comb begin
        vres        = '0;
        vres.last   = 1'b1;
        vres.pos_x  = r_m3.px;
        vres.pos_y  = r_m3.py;
        vres.pos_z  = r_m3.pz;
        vres.norm_x = r_m3.nx;
        vres.norm_y = r_m3.ny;
        vres.norm_z = r_m3.nz;
        vres.tex_s  = r_m3.tex_s;
        vres.tex_t  = r_m3.tex_t;

        tri_a            = '0;
        tri_a.last       = !r_m3.side.has_second;
        tri_a.tri_first  = r_m3.side.k1;
        tri_a.tri_second = r_m3.side.k2;
        tri_a.tri_third  = r_m3.side.k1 + 16'd1;

        tri_b            = '0;
        tri_b.last       = 1'b1;
        tri_b.tri_first  = r_m3.side.k1 + 16'd1;
        tri_b.tri_second = r_m3.side.k2;
        tri_b.tri_third  = r_m3.side.k2 + 16'd1;

        if (!r_m3.side.is_cell) begin
            first_res = vres;
        end else if (r_m3.side.has_first) begin
            first_res = tri_a;
        end else begin
            first_res = tri_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (r_vld[LAT-1]) begin
                r_out_valid <= 1'b1;
                r_pend      <= r_m3.side.is_cell && r_m3.side.has_first
                               && r_m3.side.has_second;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_out <= r_sec;
            end else if (r_vld[LAT-1]) begin
                r_out <= first_res;
                r_sec <= tri_b;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_pend_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_valid)
        else $error("second triangle pending without a shown beat");

    a_not_last_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last) |-> r_pend)
        else $error("non-final beat without a following triangle");

    a_pipe_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

endmodule

@@ hdl/uv_sphere_mesh_generator_core.sv @@
// Top level of the UV sphere mesh generator: config registers, front, queue and back end.
//
//  channel   dir  handshake        beat contents
//  i_item    in   valid / ready    opcode, stack_index, sector_index
//  o_res     out  valid / ready    last, pos_xyz, norm_xyz, tex_st, tri_first..third
//  config    in   i_cfg_we         i_cfg_idx, i_cfg_data
//
// One item enters per cycle while the queue is not full; a cell with two triangles holds the output for two beats.
// The 17 divider stages and 20 CORDIC stages make up most of the pipeline.
// The queue takes items while the back end stalls on o_res.ready, until the queue is full.
// Reset is synchronous; there is no clearing pass, the block is ready the cycle after.
module uv_sphere_mesh_generator_core import uvs_pkg::*; #(
    parameter int TRIG_TABLE_BITS = TRIG_BITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    uvs_item_if.sink              i_item,
    uvs_res_if.source             o_res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [15:0] r_radius;
    logic [7:0]  r_sectors;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= RADIUS_RESET;
            r_sectors <= SECTORS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS:  r_radius  <= i_cfg_data[15:0];
                CFG_SECTORS: r_sectors <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_q_item entry;
    t_q_item head;
    t_res    res;

    uvs_front u_front (
        .i_item    (i_item),
        .i_sectors (r_sectors),
        .i_full    (full),
        .o_push    (push),
        .o_entry   (entry)
    );

    uvs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    uvs_back #(
        .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_radius (r_radius),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_res.valid),
        .o_res    (res),
        .i_ready  (o_res.ready)
    );

    assign o_res.last       = res.last;
    assign o_res.pos_x      = res.pos_x;
    assign o_res.pos_y      = res.pos_y;
    assign o_res.pos_z      = res.pos_z;
    assign o_res.norm_x     = res.norm_x;
    assign o_res.norm_y     = res.norm_y;
    assign o_res.norm_z     = res.norm_z;
    assign o_res.tex_s      = res.tex_s;
    assign o_res.tex_t      = res.tex_t;
    assign o_res.tri_first  = res.tri_first;
    assign o_res.tri_second = res.tri_second;
    assign o_res.tri_third  = res.tri_third;

endmodule

@@ verif/uvs_checker.sv @@
// Result checker for the UV sphere mesh generator: predicts beats from accepted items.
`timescale 1ns / 1ps

module uvs_checker import uvs_pkg::*; #(
    parameter int TRIG_TABLE_BITS = TRIG_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    uvs_item_if                   item,
    uvs_res_if                    res,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    t_res        expected_beats[$];
    logic [15:0] radius_q88;
    logic [7:0]  sector_cnt;

    // atan(2^-k) in units of 2^-32 turn
    localparam longint ATAN_TURN[CORDIC_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608, 1304
    };

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // >>> on signed longint is a floor shift
    function automatic longint round_q14(longint v30);
        return clampl((v30 + 32768) >>> 16, -16384, 16384);
    endfunction

    function automatic void circle_point(input int unsigned phase, output longint c,
                                         output longint s);
        longint x, y, z, dx, dy, cr, sr;
        int unsigned ang, quad;
        ang  = (phase & ((1 << TRIG_TABLE_BITS) - 1)) << (32 - TRIG_TABLE_BITS);
        quad = ang >> 30;
        z = longint'(ang & 32'h3FFF_FFFF);
        x = 652032874;
        y = 0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TURN[k];
            end else begin
                x += dx; y -= dy; z += ATAN_TURN[k];
            end
        end
        cr = round_q14(x);
        sr = round_q14(y);
        case (quad)
            0: begin c = cr;  s = sr;  end
            1: begin c = -sr; s = cr;  end
            2: begin c = -cr; s = -sr; end
            default: begin c = sr; s = -cr; end
        endcase
    endfunction

    task automatic predict_mesh(input logic op, input logic [7:0] si, input logic [7:0] sj);
        int unsigned n, i, j, sec_ph, stk_ph, k1, k2;
        longint cs, ss, ct, st, xy, r;
        t_res v;
        n = sector_cnt;
        if (n < 2) n = 2;
        if (n > MAX_SECTORS) n = MAX_SECTORS;
        i = si;
        j = sj;
        v = '0;
        if (op == OP_VERTEX) begin
            if (i > n) i = n;
            if (j > n) j = n;
            sec_ph = (j * (1 << TRIG_TABLE_BITS) + n / 2) / n;
            stk_ph = (1 << (TRIG_TABLE_BITS - 2)) - (i * (1 << (TRIG_TABLE_BITS - 1)) + n / 2) / n;
            circle_point(sec_ph, cs, ss);
            circle_point(stk_ph, ct, st);
            r  = radius_q88;
            xy = r * ct;
            v.last   = 1'b1;
            v.pos_x  = 17'(clampl((xy * cs + (64'sd1 <<< 27)) >>> 28, -65535, 65535));
            v.pos_y  = 17'(clampl((xy * ss + (64'sd1 <<< 27)) >>> 28, -65535, 65535));
            v.pos_z  = 17'(clampl((r * st + 8192) >>> 14, -65535, 65535));
            v.norm_x = 16'(clampl((ct * cs + 8192) >>> 14, -16384, 16384));
            v.norm_y = 16'(clampl((ct * ss + 8192) >>> 14, -16384, 16384));
            v.norm_z = 16'(st);
            v.tex_s  = 17'((longint'(j) * 65536 + n / 2) / n);
            v.tex_t  = 17'((longint'(i) * 65536 + n / 2) / n);
            expected_beats.push_back(v);
        end else begin
            if (i > n - 1) i = n - 1;
            if (j > n - 1) j = n - 1;
            k1 = i * (n + 1) + j;
            k2 = k1 + n + 1;
            if (i != 0) begin
                v.last       = (i == n - 1);
                v.tri_first  = 16'(k1);
                v.tri_second = 16'(k2);
                v.tri_third  = 16'(k1 + 1);
                expected_beats.push_back(v);
            end
            if (i != n - 1) begin
                v.last       = 1'b1;
                v.tri_first  = 16'(k1 + 1);
                v.tri_second = 16'(k2);
                v.tri_third  = 16'(k2 + 1);
                expected_beats.push_back(v);
            end
        end
    endtask

    assign o_pending = expected_beats.size();

    always @(posedge i_clk) begin
        t_res got, want;
        if (!i_rst_n) begin
            radius_q88 <= RADIUS_RESET;
            sector_cnt <= SECTORS_RESET;
            o_errors   <= 0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_RADIUS) radius_q88 <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_SECTORS) sector_cnt <= i_cfg_data[7:0];
            if (item.valid && item.ready)
                predict_mesh(item.opcode, item.stack_index, item.sector_index);
            if (res.valid && res.ready) begin
                got = '{res.last, res.pos_x, res.pos_y, res.pos_z, res.norm_x, res.norm_y,
                        res.norm_z, res.tex_s, res.tex_t, res.tri_first, res.tri_second,
                        res.tri_third};
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (got !== want) begin
                        $display("%0t: beat mismatch, expected %h, actual %h", $time, want, got);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/tb_top.sv @@
// Testbench top: drives items, config writes and result back-pressure, gives the verdict.
`timescale 1ns / 1ps

module tb_top;
    import uvs_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    int                    errors;
    int                    pending;
    longint                cycles;

    uvs_item_if item_ch();
    uvs_res_if  res_ch();

    uv_sphere_mesh_generator_core dut (
        .i_clk, .i_rst_n, .i_item(item_ch), .o_res(res_ch),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    uvs_checker chk (
        .i_clk, .i_rst_n, .item(item_ch), .res(res_ch),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random stall per beat, with stall-free stretches
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            repeat (gap) @(posedge i_clk) res_ch.ready <= 1'b0;
            @(posedge i_clk) res_ch.ready <= 1'b1;
            while (!(res_ch.valid && res_ch.ready)) @(posedge i_clk);
        end
    end

    // called at the edge that took the previous beat, so nothing is offered twice
    task automatic send_item(input logic op, input logic [7:0] si, input logic [7:0] sj,
                             input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.opcode       <= op;
        item_ch.stack_index  <= si;
        item_ch.sector_index <= sj;
        do @(posedge i_clk); while (!item_ch.ready);
    endtask

    task automatic drain_and_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk) i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [7:0] si, sj;
        bit burst;
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_VERTEX;
        item_ch.stack_index = '0;
        item_ch.sector_index = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RADIUS;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config, poles, seams, clamping, both cell edges
        send_item(OP_VERTEX, 8'd0, 8'd0, 0);
        send_item(OP_VERTEX, 8'd16, 8'd16, 0);
        send_item(OP_VERTEX, 8'd8, 8'd4, 0);
        send_item(OP_VERTEX, 8'd255, 8'd255, 0);
        send_item(OP_VERTEX, 8'd3, 8'd200, 0);
        send_item(OP_CELL, 8'd0, 8'd0, 0);
        send_item(OP_CELL, 8'd15, 8'd15, 0);
        send_item(OP_CELL, 8'd7, 8'd9, 0);
        send_item(OP_CELL, 8'd255, 8'd255, 0);
        send_item(OP_CELL, 8'd0, 8'd255, 0);
        drain_and_write(CFG_RADIUS, 16'd0);
        send_item(OP_VERTEX, 8'd5, 8'd3, 0);
        send_item(OP_VERTEX, 8'd16, 8'd0, 0);
        drain_and_write(CFG_RADIUS, 16'hFFFF);
        send_item(OP_VERTEX, 8'd0, 8'd0, 0);
        send_item(OP_VERTEX, 8'd4, 8'd2, 0);
        send_item(OP_VERTEX, 8'd8, 8'd12, 0);
        drain_and_write(CFG_SECTORS, 16'hFF00);   // N=0 clamps to 2, upper bits ignored
        send_item(OP_VERTEX, 8'd1, 8'd1, 0);
        send_item(OP_CELL, 8'd0, 8'd1, 0);
        send_item(OP_CELL, 8'd1, 8'd0, 0);
        drain_and_write(CFG_SECTORS, 16'd1);
        send_item(OP_VERTEX, 8'd2, 8'd2, 0);
        send_item(OP_CELL, 8'd1, 8'd1, 0);
        drain_and_write(CFG_SECTORS, 16'd255);
        send_item(OP_VERTEX, 8'd255, 8'd128, 0);
        send_item(OP_CELL, 8'd254, 8'd254, 0);
        send_item(OP_CELL, 8'd0, 8'd100, 0);

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++) begin
            drain_and_write(CFG_RADIUS, (ph == 0) ? 16'hFFFF : 16'($urandom));
            drain_and_write(CFG_SECTORS, (ph == 1) ? 16'd2 : (ph == 2) ? 16'd255 :
                            (ph == 3) ? 16'd3 : 16'($urandom_range(0, 255)));
            for (int k = 0; k < 235; k++) begin
                if (k % 50 == 0) burst = $urandom_range(0, 1);
                if ($urandom_range(0, 9) == 0) begin
                    si = 8'($urandom);
                    sj = 8'($urandom);
                end else begin
                    si = 8'($urandom_range(0, 255));
                    sj = 8'($urandom_range(0, 255));
                    if (ph != 2 && $urandom_range(0, 1)) begin
                        si = si % 41;
                        sj = sj % 41;
                    end
                end
                send_item(1'($urandom), si, sj, burst);
            end
        end

        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
